>>> hdl/assert_macros.svh
// Assertion macros used by the checker in tlc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked at every rising clock edge, also during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> hdl/tlc_pkg.sv
// Types and constants for the TTL/LRU associative cache.
`default_nettype none
package tlc_pkg;

   localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

   localparam logic [2:0] OP_LOOKUP     = 3'd0;
   localparam logic [2:0] OP_INSERT     = 3'd1;
   localparam logic [2:0] OP_INVALIDATE = 3'd2;
   localparam logic [2:0] OP_CLEAR      = 3'd3;
   localparam logic [2:0] OP_PRUNE      = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_SCAN,
      ST_PLACE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [63:0] lookup_key;
      logic [3:0]  new_action;
      logic [31:0] new_ttl;
      logic [63:0] now_ns;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [3:0]  found_action;
      logic [31:0] found_ttl;
      logic [6:0]  pruned;
      logic [6:0]  entry_count;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic [31:0] eviction_total;
      logic [31:0] insert_total;
   } rsp_type;

   // limit holds stamp + ttl * 1e9 (mod 2^64), kept alongside the stamp
   typedef struct packed {
      logic        valid;
      logic [63:0] key;
      logic [3:0]  action;
      logic [31:0] ttl;
      logic [63:0] stamp;
      logic [63:0] limit;
   } entry_type;

endpackage
`default_nettype wire

>>> hdl/ttl_lru_assoc_cache_core.sv
// Top level of the TTL/LRU associative cache: entry ring and scan head.
//
// Usage: drive req_word and raise start while busy is low; the word is
// taken at that edge and busy rises on the next cycle. One result word
// appears on rsp_word with rsp_valid high for exactly one cycle, and busy
// falls after it. The receiver cannot stall, so the strobe is not held.
// The entries sit in a ring of ENTRIES cells that rotates once per scan,
// one slot passing the head per cycle. An insert that places a new entry
// rotates the ring a second time. An insert with zero TTL and an unused
// op skip the scan and answer straight after the ST_MUL step.
// A new word is taken in the cycle after the strobe at the earliest, so
// requests do not overlap. Before the scan the head forms new_ttl * 1e9
// in ST_MUL and adds now_ns to it in ST_ADD.
// Reset (synchronous, active high) empties every slot and zeroes the entry
// count and all running totals; slot payloads are left as they are.
`default_nettype none
module ttl_lru_assoc_cache_core
   import tlc_pkg::*;
#(
   parameter int ENTRIES = 64
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_word,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_type      rsp_word
);

   localparam int IW = $clog2(ENTRIES);
   localparam int LW = $clog2(ENTRIES + 1);
   localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] ins_limit_ff, ins_limit_in;
   logic stop_ff, stop_in;
   logic ok_ff, ok_in;
   logic [3:0] fa_ff, fa_in;
   logic [31:0] ft_ff, ft_in;
   logic [LW-1:0] pruned_ff, pruned_in;
   logic [LW-1:0] live_ff, live_in;
   logic [31:0] hit_ff, hit_in, miss_ff, miss_in;
   logic [31:0] evict_ff, evict_in, ins_ff, ins_in;
   logic have_empty_ff, have_empty_in;
   logic [IW-1:0] empty_ff, empty_in;
   logic [IW-1:0] lru_ff, lru_in;
   logic [63:0] oldest_ff, oldest_in;

   entry_type ring [ENTRIES];
   entry_type head_out;
   logic      shift;
   entry_type e;
   logic      expired, match;
   logic [IW-1:0] target;

   assign shift = (state_ff == ST_SCAN) || (state_ff == ST_PLACE);

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      if (i == ENTRIES - 1) begin : g_tail
         tlc_cell u_cell (
            .clock(clock), .reset(reset), .shift(shift), .d(head_out), .q(ring[i])
         );
      end else begin : g_body
         tlc_cell u_cell (
            .clock(clock), .reset(reset), .shift(shift), .d(ring[i+1]), .q(ring[i])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         live_ff   <= '0;
         hit_ff    <= '0;
         miss_ff   <= '0;
         evict_ff  <= '0;
         ins_ff    <= '0;
         stop_ff   <= 1'b0;
         ok_ff     <= 1'b0;
         idx_ff    <= '0;
         have_empty_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         live_ff   <= live_in;
         hit_ff    <= hit_in;
         miss_ff   <= miss_in;
         evict_ff  <= evict_in;
         ins_ff    <= ins_in;
         stop_ff   <= stop_in;
         ok_ff     <= ok_in;
         idx_ff    <= idx_in;
         have_empty_ff <= have_empty_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      prod_ff      <= prod_in;
      ins_limit_ff <= ins_limit_in;
      fa_ff        <= fa_in;
      ft_ff        <= ft_in;
      pruned_ff    <= pruned_in;
      empty_ff     <= empty_in;
      lru_ff       <= lru_in;
      oldest_ff    <= oldest_in;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      prod_in       = prod_ff;
      ins_limit_in  = ins_limit_ff;
      stop_in       = stop_ff;
      ok_in         = ok_ff;
      fa_in         = fa_ff;
      ft_in         = ft_ff;
      pruned_in     = pruned_ff;
      live_in       = live_ff;
      hit_in        = hit_ff;
      miss_in       = miss_ff;
      evict_in      = evict_ff;
      ins_in        = ins_ff;
      have_empty_in = have_empty_ff;
      empty_in      = empty_ff;
      lru_in        = lru_ff;
      oldest_in     = oldest_ff;

      e        = ring[0];
      head_out = e;
      expired  = e.limit < req_ff.now_ns;
      match    = e.key == req_ff.lookup_key;
      target   = have_empty_ff ? empty_ff : lru_ff;
      busy     = state_ff != ST_IDLE;
      rsp_valid = 1'b0;

      rsp_word.ok             = ok_ff;
      rsp_word.found_action   = fa_ff;
      rsp_word.found_ttl      = ft_ff;
      rsp_word.pruned         = pruned_ff[6:0];
      rsp_word.entry_count    = live_ff[6:0];
      rsp_word.hit_total      = hit_ff;
      rsp_word.miss_total     = miss_ff;
      rsp_word.eviction_total = evict_ff;
      rsp_word.insert_total   = ins_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in        = req_word;
               idx_in        = '0;
               stop_in       = 1'b0;
               ok_in         = (req_word.op == OP_INSERT) && (req_word.new_ttl != '0);
               fa_in         = '0;
               ft_in         = '0;
               pruned_in     = '0;
               have_empty_in = 1'b0;
               empty_in      = '0;
               lru_in        = '0;
               oldest_in     = '1;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = 64'(req_ff.new_ttl) * 64'(NS_PER_SEC);
            if (req_ff.op > OP_PRUNE ||
                (req_ff.op == OP_INSERT && req_ff.new_ttl == '0)) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            ins_limit_in = req_ff.now_ns + prod_ff;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (!stop_ff) begin
               case (req_ff.op)
                  OP_LOOKUP: begin
                     if (e.valid && match) begin
                        stop_in = 1'b1;
                        if (expired) begin
                           miss_in = miss_ff + 1'b1;
                        end else begin
                           ok_in  = 1'b1;
                           fa_in  = e.action;
                           ft_in  = e.ttl;
                           hit_in = hit_ff + 1'b1;
                           if (e.stamp < req_ff.now_ns) begin
                              head_out.stamp = req_ff.now_ns;
                              head_out.limit = e.limit + (req_ff.now_ns - e.stamp);
                           end
                        end
                     end
                  end
                  OP_INSERT: begin
                     if (!e.valid || expired) begin
                        if (e.valid) begin
                           head_out.valid = 1'b0;
                           live_in = live_ff - 1'b1;
                        end
                        if (!have_empty_ff) begin
                           have_empty_in = 1'b1;
                           empty_in      = idx_ff;
                        end
                     end else if (match) begin
                        head_out.action = req_ff.new_action;
                        head_out.ttl    = req_ff.new_ttl;
                        head_out.stamp  = req_ff.now_ns;
                        head_out.limit  = ins_limit_ff;
                        stop_in         = 1'b1;
                     end else if (e.stamp < oldest_ff) begin
                        oldest_in = e.stamp;
                        lru_in    = idx_ff;
                     end
                  end
                  OP_INVALIDATE: begin
                     if (e.valid && match) begin
                        head_out.valid = 1'b0;
                        live_in = live_ff - 1'b1;
                        ok_in   = 1'b1;
                        stop_in = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     head_out.valid = 1'b0;
                     live_in = '0;
                  end
                  OP_PRUNE: begin
                     if (e.valid && expired) begin
                        head_out.valid = 1'b0;
                        live_in   = live_ff - 1'b1;
                        pruned_in = pruned_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (idx_ff == LAST) begin
               idx_in   = '0;
               state_in = ST_RESP;
               if (req_ff.op == OP_LOOKUP && !stop_in) begin
                  miss_in = miss_ff + 1'b1;
               end
               if (req_ff.op == OP_INSERT && !stop_in) begin
                  // no live match: place the new word on a second turn
                  state_in = ST_PLACE;
                  ins_in   = ins_ff + 1'b1;
                  if (have_empty_in) begin
                     live_in = live_in + 1'b1;
                  end else begin
                     evict_in = evict_ff + 1'b1;
                  end
               end
            end
         end
         ST_PLACE: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == target) begin
               head_out.valid  = 1'b1;
               head_out.key    = req_ff.lookup_key;
               head_out.action = req_ff.new_action;
               head_out.ttl    = req_ff.new_ttl;
               head_out.stamp  = req_ff.now_ns;
               head_out.limit  = ins_limit_ff;
            end
            if (idx_ff == LAST) begin
               idx_in   = '0;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> hdl/tlc_cell.sv
// One slot of the entry ring; takes its neighbor's entry on every shift.
`default_nettype none
module tlc_cell
   import tlc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      shift,
   input  wire entry_type d,
   output entry_type      q
);

   logic      valid_ff;
   entry_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= d.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= d;
      end
   end

   always_comb begin
      q       = data_ff;
      q.valid = valid_ff;
   end

endmodule
`default_nettype wire

>>> hdl/tlc_checker.sv
// Port-level checks for the cache core, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module tlc_checker
   import tlc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_word
);

   `ASSERT_CLK(a_accept_busy, clock, reset, (start && !busy) |=> busy)
   `ASSERT_CLK(a_rsp_in_busy, clock, reset, rsp_valid |-> busy)
   `ASSERT_CLK(a_rsp_then_idle, clock, reset, rsp_valid |=> (!busy && !rsp_valid))
   `ASSERT_CLK(a_miss_no_data, clock, reset,
      (rsp_valid && !rsp_word.ok) |-> (rsp_word.found_action == '0 && rsp_word.found_ttl == '0))
   `ASSERT_CLK(a_busy_from_start, clock, reset, $rose(busy) |-> $past(start))

endmodule

bind ttl_lru_assoc_cache_core tlc_checker u_tlc_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_word(rsp_word)
);
`default_nettype wire

>>> verif/testbench.sv
// Self-checking bench for the TTL/LRU associative cache core.
module testbench;
   import tlc_pkg::*;

   localparam int SLOTS = 64;
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam logic [63:0] NS_SEC = 64'd1000000000;

   class cache_scoreboard;
      logic        used[SLOTS];
      logic [63:0] key_of[SLOTS];
      logic [3:0]  act_of[SLOTS];
      logic [31:0] ttl_of[SLOTS];
      logic [63:0] stamp_of[SLOTS];
      logic [6:0]  live;
      logic [31:0] hits, misses, evicts, inserts;
      rsp_type     awaited[$];
      int          errors;

      function new();
         for (int i = 0; i < SLOTS; i++) used[i] = 1'b0;
         live = '0; hits = '0; misses = '0; evicts = '0; inserts = '0;
         errors = 0;
      endfunction

      function logic stale(int i, logic [63:0] now);
         logic [63:0] lim;
         lim = stamp_of[i] + {32'd0, ttl_of[i]} * NS_SEC;
         return lim < now;
      endfunction

      function void drop(int i);
         used[i] = 1'b0;
         live = live - 7'd1;
      endfunction

      // work out the answer to an accepted request and queue it
      function void note(req_type r);
         rsp_type e;
         int      empty, lru;
         logic    done;
         logic [63:0] oldest;
         e = '0;
         case (r.op)
            OP_LOOKUP: begin
               done = 1'b0;
               for (int i = 0; i < SLOTS && !done; i++) begin
                  if (used[i] && key_of[i] == r.lookup_key) begin
                     done = 1'b1;
                     if (stale(i, r.now_ns)) misses++;
                     else begin
                        e.ok = 1'b1;
                        e.found_action = act_of[i];
                        e.found_ttl = ttl_of[i];
                        if (stamp_of[i] < r.now_ns) stamp_of[i] = r.now_ns;
                        hits++;
                     end
                  end
               end
               if (!done) misses++;
            end
            OP_INSERT: begin
               if (r.new_ttl != 0) begin
                  empty = -1; lru = 0; oldest = '1; done = 1'b0;
                  for (int i = 0; i < SLOTS && !done; i++) begin
                     if (!used[i]) begin
                        if (empty < 0) empty = i;
                     end else if (stale(i, r.now_ns)) begin
                        drop(i);
                        if (empty < 0) empty = i;
                     end else if (key_of[i] == r.lookup_key) begin
                        act_of[i] = r.new_action;
                        ttl_of[i] = r.new_ttl;
                        stamp_of[i] = r.now_ns;
                        done = 1'b1;
                     end else if (stamp_of[i] < oldest) begin
                        oldest = stamp_of[i];
                        lru = i;
                     end
                  end
                  if (!done) begin
                     if (empty >= 0) begin
                        lru = empty;
                        live = live + 7'd1;
                     end else evicts++;
                     used[lru] = 1'b1;
                     key_of[lru] = r.lookup_key;
                     act_of[lru] = r.new_action;
                     ttl_of[lru] = r.new_ttl;
                     stamp_of[lru] = r.now_ns;
                     inserts++;
                  end
                  e.ok = 1'b1;
               end
            end
            OP_INVALIDATE: begin
               done = 1'b0;
               for (int i = 0; i < SLOTS && !done; i++)
                  if (used[i] && key_of[i] == r.lookup_key) begin
                     drop(i);
                     e.ok = 1'b1;
                     done = 1'b1;
                  end
            end
            OP_CLEAR: begin
               for (int i = 0; i < SLOTS; i++) used[i] = 1'b0;
               live = '0;
            end
            OP_PRUNE: begin
               for (int i = 0; i < SLOTS; i++)
                  if (used[i] && stale(i, r.now_ns)) begin
                     drop(i);
                     e.pruned = e.pruned + 7'd1;
                  end
            end
            default: ;
         endcase
         e.entry_count = live;
         e.hit_total = hits;
         e.miss_total = misses;
         e.eviction_total = evicts;
         e.insert_total = inserts;
         awaited.push_back(e);
      endfunction

      function void cmp(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check(rsp_type got);
         rsp_type w;
         if (awaited.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
            return;
         end
         w = awaited.pop_front();
         cmp("ok", w.ok, got.ok);
         cmp("found_action", w.found_action, got.found_action);
         cmp("found_ttl", w.found_ttl, got.found_ttl);
         cmp("pruned", w.pruned, got.pruned);
         cmp("entry_count", w.entry_count, got.entry_count);
         cmp("hit_total", w.hit_total, got.hit_total);
         cmp("miss_total", w.miss_total, got.miss_total);
         cmp("eviction_total", w.eviction_total, got.eviction_total);
         cmp("insert_total", w.insert_total, got.insert_total);
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_word = '0;
   logic    busy, rsp_valid;
   rsp_type rsp_word;

   cache_scoreboard sb = new();
   logic [63:0] key_pool[80];
   logic [63:0] clock_ns;
   logic        calm;

   ttl_lru_assoc_cache_core u_top (
      .clock(clock), .reset(reset), .start(start), .req_word(req_word),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check(rsp_word);
   end

   // hold the word until the block takes it; start is left high
   task send(input req_type r);
      req_word <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note(r);
   endtask

   task idle_gap();
      if (!calm && $urandom_range(0, 99) < 30) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   task issue(input logic [2:0] op, input logic [63:0] key, input logic [3:0] act,
              input logic [31:0] ttl, input logic [63:0] now);
      req_type r;
      r.op = op; r.lookup_key = key; r.new_action = act;
      r.new_ttl = ttl; r.now_ns = now;
      idle_gap();
      send(r);
   endtask

   task random_item(int n);
      logic [2:0]  op;
      logic [63:0] key;
      logic [31:0] ttl;
      int          pick;
      clock_ns = clock_ns + 64'($urandom_range(0, 300000000));
      pick = $urandom_range(0, 99);
      if (pick < 40) op = OP_LOOKUP;
      else if (pick < 80) op = OP_INSERT;
      else if (pick < 88) op = OP_INVALIDATE;
      else if (pick < 94) op = OP_PRUNE;
      else if (pick < 96) op = OP_CLEAR;
      else op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                        : key_pool[$urandom_range(0, 79)];
      pick = $urandom_range(0, 99);
      if (pick < 5) ttl = '0;
      else if (pick < 15) ttl = $urandom;
      else ttl = $urandom_range(1, 3);
      if ($urandom_range(0, 19) == 0) clock_ns = {$urandom, $urandom};
      calm = (n >= 300 && n < 420);
      issue(op, key, 4'($urandom), ttl, clock_ns);
   endtask

   initial begin
      calm = 1'b0;
      for (int i = 0; i < 80; i++) key_pool[i] = {$urandom, $urandom};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      issue(OP_LOOKUP, '1, 4'd0, 32'd5, 64'd0);
      issue(OP_INSERT, '1, 4'hF, 32'd0, 64'd100);
      issue(OP_INSERT, '1, 4'hF, '1, '1);
      issue(OP_LOOKUP, '1, 4'd0, '0, '1);
      issue(OP_INSERT, 64'd0, 4'd0, 32'd1, 64'd0);
      issue(OP_LOOKUP, 64'd0, 4'd0, 32'd0, 64'd1000000000);
      issue(OP_LOOKUP, 64'd0, 4'd0, 32'd0, 64'd1000000001);
      issue(OP_INSERT, 64'd0, 4'd9, 32'd1, 64'd5);
      issue(OP_INSERT, 64'd7, 4'd3, 32'd1, 64'hFFFF_FFFF_F000_0000);
      issue(OP_LOOKUP, 64'd7, 4'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      issue(OP_PRUNE, 64'd0, 4'd0, 32'd0, 64'd3000000000);
      issue(OP_INVALIDATE, '1, 4'd0, 32'd0, 64'd0);
      issue(OP_INVALIDATE, '1, 4'd0, 32'd0, 64'd0);
      issue(OP_INSERT, 64'h5555_AAAA_5555_AAAA, 4'd5, 32'hAAAA_5555, 64'd10);
      issue(OP_LOOKUP, 64'h5555_AAAA_5555_AAAA, 4'd0, 32'd0, 64'd9);
      issue(OP_SPARE_LO, '1, 4'hF, '1, '1);
      issue(OP_SPARE_MID, '0, 4'd0, 32'd0, 64'd0);
      issue(OP_SPARE_HI, '0, 4'd0, 32'd0, 64'd0);
      issue(OP_CLEAR, '0, 4'd0, 32'd0, 64'd0);
      issue(OP_LOOKUP, 64'h5555_AAAA_5555_AAAA, 4'd0, 32'd0, 64'd11);
      drain();

      clock_ns = 64'd0;
      for (int n = 0; n < 900; n++) begin
         random_item(n);
         if (n == 450) drain();
      end

      drain();
      repeat (140) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0)
         $display("ttl_lru_assoc_cache_core verification clean");
      else
         $display("ttl_lru_assoc_cache_core verification failed");
      $finish;
   end

   initial begin
      #40000000;
      $display("ttl_lru_assoc_cache_core verification failed");
      $finish;
   end

endmodule
